// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the parity generator RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_SYNC(lbl, clk, rstn, !(cond), msg)

`endif

// ----- rtl/core/rsp_pkg.sv -----
// Package for the Reed-Solomon parity generator: item and status types,
// fixed constants and GF(2^8) helpers over field polynomial 0x11D. No dependencies.
package rsp_pkg;

    localparam logic [7:0] GF_POLY_LOW  = 8'h1D;
    localparam logic [7:0] GF_ALPHA     = 8'h02;
    localparam int         RESET_PARITY = 10;
    localparam int         CFG_W        = 5;
    localparam int         QDEPTH       = 4;
    localparam int         QAW          = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic busy;
        logic clr;
    } t_gen_status;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] z;
        z = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            z = {z[6:0], 1'b0} ^ (z[7] ? GF_POLY_LOW : 8'h00);
            if (b[i]) begin
                z = z ^ a;
            end
        end
        return z;
    endfunction

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
    endfunction

endpackage

// ----- rtl/core/rsp_front.sv -----
// Front end: accepts data beats into a short queue for the encoder back end.
// Depends on rsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic           i_hold,
    output logic           o_valid,
    output rsp_pkg::t_item o_item,
    input  logic           i_take
);

    rsp_pkg::t_item                r_mem [rsp_pkg::QDEPTH];
    logic [rsp_pkg::QAW-1:0]       r_wp;
    logic [rsp_pkg::QAW-1:0]       r_rp;
    logic [rsp_pkg::QAW:0]         r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign o_full  = (r_cnt == (rsp_pkg::QAW+1)'(rsp_pkg::QDEPTH)) || i_hold;
    assign w_push  = i_push && !o_full;
    assign o_valid = (r_cnt != '0);
    assign w_pop   = i_take && o_valid;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{data: i_data_byte, last: i_last_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_q_over, i_clk, i_rst_n, r_cnt > (rsp_pkg::QAW+1)'(rsp_pkg::QDEPTH), "queue count above depth")

endmodule

// ----- rtl/core/rsp_gen.sv -----
// Generator polynomial unit: holds the parity count and derives the
// coefficients one root per cycle. Depends on rsp_pkg.
module rsp_gen #(
    parameter int MAX_PARITY = 30,
    parameter int CW         = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsp_pkg::CFG_W-1:0]       i_cfg_parity_count,
    output logic [CW-1:0]                   o_count,
    output logic [MAX_PARITY-1:0][7:0]      o_gen,
    output rsp_pkg::t_gen_status            o_status
);

    localparam int RST_N = (rsp_pkg::RESET_PARITY > MAX_PARITY) ? MAX_PARITY
                                                                : rsp_pkg::RESET_PARITY;

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_iter;
    logic [7:0]                   r_root;
    logic [MAX_PARITY-1:0][7:0]   r_gen;
    logic [MAX_PARITY-1:0][7:0]   w_shift;
    logic [MAX_PARITY-1:0][7:0]   n_gen;
    logic [CW-1:0]                w_n;
    logic                         w_wr;
    logic                         w_busy;

    assign w_busy      = (r_iter != '0);
    assign o_cfg_ready = !w_busy;
    assign w_wr        = i_cfg_valid && o_cfg_ready;
    assign o_count     = r_count;
    assign o_gen       = r_gen;
    assign o_status    = '{busy: w_busy, clr: w_wr};
    assign w_shift     = r_gen >> 8;

    always_comb begin
        int v;
        v = int'(i_cfg_parity_count);
        if (v == 0) begin
            w_n = CW'(1);
        end else if (v > MAX_PARITY) begin
            w_n = CW'(MAX_PARITY);
        end else begin
            w_n = CW'(v);
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_PARITY; j++) begin
            n_gen[j] = rsp_pkg::gf_mul(r_gen[j], r_root) ^ w_shift[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(RST_N);
            r_iter  <= CW'(RST_N);
            r_root  <= 8'h01;
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_gen[j] <= (j == RST_N - 1) ? 8'h01 : 8'h00;
            end
        end else if (w_wr) begin
            r_count <= w_n;
            r_iter  <= w_n;
            r_root  <= 8'h01;
            for (int j = 0; j < MAX_PARITY; j++) begin
                r_gen[j] <= (CW'(j) == w_n - 1'b1) ? 8'h01 : 8'h00;
            end
        end else if (w_busy) begin
            r_iter <= r_iter - 1'b1;
            r_root <= rsp_pkg::gf_xtime(r_root);
            r_gen  <= n_gen;
        end
    end

endmodule

// ----- rtl/core/rsp_back.sv -----
// Back end: division shift register over all taps and the parity drain register.
// Depends on rsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsp_back #(
    parameter int MAX_PARITY = 30,
    parameter int CW         = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  rsp_pkg::t_item              i_item,
    output logic                        o_take,
    input  logic [CW-1:0]               i_count,
    input  logic [MAX_PARITY-1:0][7:0]  i_gen,
    input  rsp_pkg::t_gen_status        i_gen_status,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [7:0]                  o_parity_byte,
    output logic                        o_last_parity
);

    logic [MAX_PARITY-1:0][7:0]  r_rem;
    logic [MAX_PARITY-1:0][7:0]  r_par;
    logic [CW-1:0]               r_left;
    logic [MAX_PARITY-1:0][7:0]  w_shift;
    logic [MAX_PARITY-1:0][7:0]  n_rem;
    logic [7:0]                  w_factor;
    logic                        w_active;
    logic                        w_free;
    logic                        w_load;

    assign w_active      = (r_left != '0);
    assign w_free        = !w_active || (i_pop && r_left == CW'(1));
    assign o_take        = i_valid && !i_gen_status.busy && (!i_item.last || w_free);
    assign w_load        = o_take && i_item.last;
    assign o_empty       = !w_active;
    assign o_parity_byte = r_par[0];
    assign o_last_parity = (r_left == CW'(1));

    assign w_factor = i_item.data ^ r_rem[0];
    assign w_shift  = r_rem >> 8;

    always_comb begin
        for (int i = 0; i < MAX_PARITY; i++) begin
            n_rem[i] = w_shift[i] ^ rsp_pkg::gf_mul(i_gen[i], w_factor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_left <= '0;
        end else begin
            if (w_load && !i_gen_status.clr) begin
                r_par  <= n_rem;
                r_left <= i_count;
            end else if (i_pop && w_active) begin
                r_par  <= r_par >> 8;
                r_left <= r_left - 1'b1;
            end
            if (i_gen_status.clr) begin
                r_rem <= '0;
            end else if (w_load) begin
                r_rem <= '0;
            end else if (o_take) begin
                r_rem <= n_rem;
            end
        end
    end

    `ASSERT_SYNC(a_load_free, i_clk, i_rst_n, w_load |-> w_free, "load while draining")
    `ASSERT_NEVER(a_take_busy, i_clk, i_rst_n, o_take && i_gen_status.busy, "take during derive")
    `ASSERT_SYNC(a_drain_hold, i_clk, i_rst_n, (w_active && !i_pop) |=> $stable(r_left), "no hold")

endmodule

// ----- rtl/core/reed_solomon_parity_generator.sv -----
// Channel   | Handshake                  | Payload
// input     | i_push / o_full            | i_data_byte, i_last_byte
// result    | o_empty / i_pop            | o_parity_byte, o_last_parity
// config    | i_cfg_valid / o_cfg_ready  | i_cfg_parity_count
// One data byte per cycle while o_full is low; the back end takes each from the queue.
// A last byte loads n parity bytes into the drain register; they leave one per pop.
// A further last byte waits in the queue until the drain is on its final beat.
// After reset and each config write the generator derives its coefficients, full held high.
// Top level of the parity generator; depends on rsp_pkg, rsp_front, rsp_gen, rsp_back.
module reed_solomon_parity_generator #(
    parameter int MAX_PARITY = 30
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_last_byte,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [7:0]                   o_parity_byte,
    output logic                         o_last_parity,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rsp_pkg::CFG_W-1:0]    i_cfg_parity_count
);

    localparam int CW = $clog2(MAX_PARITY + 1);

    rsp_pkg::t_item               w_item;
    rsp_pkg::t_gen_status         w_gen_status;
    logic                         w_valid;
    logic                         w_take;
    logic [CW-1:0]                w_count;
    logic [MAX_PARITY-1:0][7:0]   w_gen;

    rsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_hold      (w_gen_status.busy),
        .o_valid     (w_valid),
        .o_item      (w_item),
        .i_take      (w_take)
    );

    rsp_gen #(
        .MAX_PARITY (MAX_PARITY),
        .CW         (CW)
    ) u_gen (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_parity_count (i_cfg_parity_count),
        .o_count            (w_count),
        .o_gen              (w_gen),
        .o_status           (w_gen_status)
    );

    rsp_back #(
        .MAX_PARITY (MAX_PARITY),
        .CW         (CW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid),
        .i_item        (w_item),
        .o_take        (w_take),
        .i_count       (w_count),
        .i_gen         (w_gen),
        .i_gen_status  (w_gen_status),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_parity_byte (o_parity_byte),
        .o_last_parity (o_last_parity)
    );

endmodule
